// ----- rtl/rsc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the stepped RGB crossfade: widths, reset values, register
// indexes, sequencer states and the divider request/response words.
// No dependencies.
package rsc_pkg;

  localparam int COLOR_W = 8;
  localparam int NUM_CH  = 3;
  localparam int CH_W    = 2;
  localparam int IDX_W   = 9;
  localparam int MS_W    = 16;
  localparam int STEPS_W = 8;
  localparam int DIV_W   = 16;
  localparam int DVSR_W  = 8;
  localparam int CNT_W   = $clog2(DIV_W + 1);
  localparam int PROD_W  = IDX_W + COLOR_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION_MS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT    = 1'd1;

  localparam logic [MS_W-1:0]    TRANSITION_MS_RST = 16'd500;
  localparam logic [STEPS_W-1:0] STEP_COUNT_RST    = 8'd30;
  localparam logic [MS_W-1:0]    MS_MAX            = {MS_W{1'b1}};

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Q_ISSUE,
    ST_Q_WAIT,
    ST_D_ISSUE,
    ST_D_WAIT,
    ST_S_ISSUE,
    ST_S_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  quo;
    logic [DVSR_W-1:0] rem;
  } div_rsp_t;

endpackage

// ----- rtl/rsc_in_if.sv -----
`timescale 1ns / 1ps
// Input word channel: valid/ready with command and target color.
// Depends on rsc_pkg.
interface rsc_in_if;
  import rsc_pkg::*;

  logic               valid;
  logic               ready;
  logic               cmd;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic               effect_selected;
  logic               light_on;

  modport source (output valid, cmd, red, green, blue, effect_selected, light_on,
                  input ready);
  modport sink (input valid, cmd, red, green, blue, effect_selected, light_on,
                output ready);
endinterface

// ----- rtl/rsc_out_if.sv -----
`timescale 1ns / 1ps
// Result word channel: valid/ready with displayed color and status.
// Depends on rsc_pkg.
interface rsc_out_if;
  import rsc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] out_red;
  logic [COLOR_W-1:0] out_green;
  logic [COLOR_W-1:0] out_blue;
  logic               refreshed;
  logic               fading;

  modport source (output valid, out_red, out_green, out_blue, refreshed, fading,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, refreshed, fading,
                output ready);
endinterface

// ----- rtl/rsc_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel: valid/ready with register index and data.
// Depends on rsc_pkg.
interface rsc_cfg_if;
  import rsc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/rsc_div.sv -----
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rsc_pkg (div_req_t, div_rsp_t, widths).
module rsc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rsc_pkg::div_req_t req,
  output rsc_pkg::div_rsp_t rsp
);
  import rsc_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DVSR_W-1:0] rem_r, rem_nxt;
  logic [DVSR_W-1:0] dvsr_r, dvsr_nxt;
  logic [DVSR_W:0]   trial;
  logic [DVSR_W:0]   diff;
  logic              ge;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvsr_r};
  assign diff  = trial - {1'b0, dvsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_W);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvsr_nxt = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      rem_nxt = ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- rtl/rgb_stepped_crossfade_unit.sv -----
`timescale 1ns / 1ps
// Stepped RGB crossfade: set words store a target, tick words advance the fade.
// Tick work runs on the shared 16-bit restoring divider: fade start 3 divides,
// step delay 1 divide, step 3 divides. One word at a time; next word after result.
// Reset (synchronous, rst_n low): color, target, fade state cleared, registers
// back to 500 ms / 30 steps. Depends on rsc_pkg, rsc_*_if, rsc_div.
module rgb_stepped_crossfade_unit (
  input  logic         clk,
  input  logic         rst_n,
  rsc_in_if.sink       in_if,
  rsc_out_if.source    out_if,
  rsc_cfg_if.sink      cfg_if
);
  import rsc_pkg::*;

  state_t state_r, state_nxt;

  logic [MS_W-1:0]    trans_ms_r;
  logic [STEPS_W-1:0] step_cnt_r;

  logic [COLOR_W-1:0] cur_r [NUM_CH];
  logic [COLOR_W-1:0] cur_nxt [NUM_CH];
  logic [COLOR_W-1:0] tgt_r [NUM_CH];
  logic [COLOR_W-1:0] tgt_nxt [NUM_CH];
  logic [IDX_W-1:0]   q_r [NUM_CH];
  logic [IDX_W-1:0]   q_nxt [NUM_CH];
  logic [IDX_W-1:0]   rm_r [NUM_CH];
  logic [IDX_W-1:0]   rm_nxt [NUM_CH];

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             pending_r, pending_nxt;
  logic             active_r, active_nxt;
  logic [MS_W-1:0]  ms_r, ms_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic             refr_r, refr_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] o_red_r, o_green_r, o_blue_r;
  logic               o_refr_r, o_fading_r;
  logic               out_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               in_acc;
  logic [STEPS_W-1:0] n_eff;
  logic [IDX_W-1:0]   diff;
  logic [IDX_W-1:0]   mag;
  logic               neg;
  logic [IDX_W-1:0]   quo9, rem9;
  logic [IDX_W-1:0]   a9;
  logic [COLOR_W-1:0] a8;
  logic [PROD_W-1:0]  prod;
  logic               extra;
  logic               dneg;
  logic [IDX_W-1:0]   delta;
  logic [IDX_W-1:0]   idx_inc;

  rsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_acc      = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign n_eff       = (step_cnt_r == '0) ? STEPS_W'(1) : step_cnt_r;

  // fade start: per-channel sign and magnitude of the difference
  assign diff = {1'b0, tgt_r[ch_r]} - {1'b0, cur_r[ch_r]};
  assign neg  = diff[IDX_W-1];
  assign mag  = neg ? (IDX_W'(0) - diff) : diff;
  assign quo9 = {1'b0, div_rsp.quo[COLOR_W-1:0]};
  assign rem9 = {1'b0, div_rsp.rem};

  // step: remainder share test (i*a) mod n < a
  assign a9      = rm_r[ch_r][IDX_W-1] ? (IDX_W'(0) - rm_r[ch_r]) : rm_r[ch_r];
  assign a8      = a9[COLOR_W-1:0];
  assign prod    = idx_r * a8;
  assign extra   = div_rsp.rem < a8;
  assign dneg    = q_r[ch_r][IDX_W-1] || rm_r[ch_r][IDX_W-1];
  assign delta   = q_r[ch_r] + (extra ? (dneg ? {IDX_W{1'b1}} : IDX_W'(1)) : IDX_W'(0));
  assign idx_inc = idx_r + IDX_W'(1);

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    tgt_nxt     = tgt_r;
    q_nxt       = q_r;
    rm_nxt      = rm_r;
    idx_nxt     = idx_r;
    pending_nxt = pending_r;
    active_nxt  = active_r;
    ms_nxt      = ms_r;
    ch_nxt      = ch_r;
    refr_nxt    = refr_r;
    out_load    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = n_eff;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          refr_nxt = 1'b0;
          if (in_if.cmd == CMD_SET) begin
            tgt_nxt[0]  = in_if.red;
            tgt_nxt[1]  = in_if.green;
            tgt_nxt[2]  = in_if.blue;
            pending_nxt = 1'b1;
            state_nxt   = ST_DONE;
          end else begin
            if (ms_r != MS_MAX) begin
              ms_nxt = ms_r + MS_W'(1);
            end
            if (pending_r && in_if.effect_selected && in_if.light_on) begin
              state_nxt = ST_DONE;
            end else if (pending_r) begin
              pending_nxt = 1'b0;
              if (trans_ms_r == '0 || in_if.effect_selected) begin
                cur_nxt    = tgt_r;
                active_nxt = 1'b0;
                refr_nxt   = 1'b1;
                state_nxt  = ST_DONE;
              end else begin
                active_nxt = 1'b1;
                idx_nxt    = IDX_W'(1);
                ch_nxt     = '0;
                state_nxt  = ST_Q_ISSUE;
              end
            end else if (active_r) begin
              state_nxt = ST_D_ISSUE;
            end else begin
              state_nxt = ST_DONE;
            end
          end
        end
      end
      ST_Q_ISSUE: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(mag[COLOR_W-1:0]);
        state_nxt        = ST_Q_WAIT;
      end
      ST_Q_WAIT: begin
        if (div_rsp.done) begin
          q_nxt[ch_r]  = neg ? (IDX_W'(0) - quo9) : quo9;
          rm_nxt[ch_r] = neg ? (IDX_W'(0) - rem9) : rem9;
          if (ch_r == CH_W'(NUM_CH - 1)) begin
            state_nxt = ST_D_ISSUE;
          end else begin
            ch_nxt    = ch_r + CH_W'(1);
            state_nxt = ST_Q_ISSUE;
          end
        end
      end
      ST_D_ISSUE: begin
        div_req.start    = 1'b1;
        div_req.dividend = trans_ms_r;
        state_nxt        = ST_D_WAIT;
      end
      ST_D_WAIT: begin
        if (div_rsp.done) begin
          if (ms_r > div_rsp.quo || ms_r == MS_MAX) begin
            ms_nxt    = '0;
            ch_nxt    = '0;
            state_nxt = ST_S_ISSUE;
          end else begin
            if (idx_r > {1'b0, n_eff}) begin
              active_nxt = 1'b0;
            end
            state_nxt = ST_DONE;
          end
        end
      end
      ST_S_ISSUE: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod[DIV_W-1:0];
        state_nxt        = ST_S_WAIT;
      end
      ST_S_WAIT: begin
        if (div_rsp.done) begin
          cur_nxt[ch_r] = cur_r[ch_r] + delta[COLOR_W-1:0];
          if (ch_r == CH_W'(NUM_CH - 1)) begin
            idx_nxt  = idx_inc;
            refr_nxt = 1'b1;
            if (idx_inc > {1'b0, n_eff}) begin
              active_nxt = 1'b0;
            end
            state_nxt = ST_DONE;
          end else begin
            ch_nxt    = ch_r + CH_W'(1);
            state_nxt = ST_S_ISSUE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      trans_ms_r  <= TRANSITION_MS_RST;
      step_cnt_r  <= STEP_COUNT_RST;
      for (int c = 0; c < NUM_CH; c++) begin
        cur_r[c] <= '0;
        tgt_r[c] <= '0;
        q_r[c]   <= '0;
        rm_r[c]  <= '0;
      end
      idx_r       <= '0;
      pending_r   <= 1'b0;
      active_r    <= 1'b0;
      ms_r        <= '0;
      ch_r        <= '0;
      refr_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_r     <= cur_nxt;
      tgt_r     <= tgt_nxt;
      q_r       <= q_nxt;
      rm_r      <= rm_nxt;
      idx_r     <= idx_nxt;
      pending_r <= pending_nxt;
      active_r  <= active_nxt;
      ms_r      <= ms_nxt;
      ch_r      <= ch_nxt;
      refr_r    <= refr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_TRANSITION_MS: trans_ms_r <= cfg_if.data[MS_W-1:0];
          CFG_STEP_COUNT:    step_cnt_r <= cfg_if.data[STEPS_W-1:0];
          default: begin
          end
        endcase
      end
    end
    if (out_load) begin
      o_red_r    <= cur_r[0];
      o_green_r  <= cur_r[1];
      o_blue_r   <= cur_r[2];
      o_refr_r   <= refr_r;
      o_fading_r <= active_r;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.out_red   = o_red_r;
  assign out_if.out_green = o_green_r;
  assign out_if.out_blue  = o_blue_r;
  assign out_if.refreshed = o_refr_r;
  assign out_if.fading    = o_fading_r;

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_Q_WAIT || state_r == ST_D_WAIT ||
                      state_r == ST_S_WAIT))
    else $error("divider result outside a wait state");

  a_active_idx: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (idx_r != '0))
    else $error("active fade with zero step index");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_if.valid && state_r == ST_IDLE))
    else $error("result load did not return to idle");

endmodule

// ----- tb/rgb_stepped_crossfade_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rgb_stepped_crossfade_unit: directed table, then random phases
// checked against a cycle-free crossfade predictor. Depends on rsc_pkg and the rsc_*_if files.
module rgb_stepped_crossfade_unit_tb;
  import rsc_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 200;
  localparam int PHASE_WORDS  = 85;
  localparam int NUM_PHASES   = 12;
  localparam int LIMIT_NS     = 500_000_000;
  localparam int IDX_MASK     = 'h1FF;

  typedef struct packed {
    logic               cmd;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               effect_selected;
    logic               light_on;
  } fade_word_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               refreshed;
    logic               fading;
  } shown_color_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_REGS} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    fade_word_t           word;
    logic                 typed;
    shown_color_t         want;
    logic [MS_W-1:0]      fade_ms;
    logic [STEPS_W-1:0]   steps;
  } plan_row_t;

  typedef enum int {
    PROF_SHORT, PROF_JUMP, PROF_DENSE, PROF_SINGLE, PROF_MIXED, PROF_WILD
  } fade_profile_t;

  logic clk;
  logic rst_n;

  rsc_in_if  in_ch ();
  rsc_out_if out_ch ();
  rsc_cfg_if cfg_ch ();

  rgb_stepped_crossfade_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // predictor state
  logic [COLOR_W-1:0] shown_rgb [NUM_CH];
  logic [COLOR_W-1:0] goal_rgb  [NUM_CH];
  int                 quot_rgb  [NUM_CH];
  int                 rem_rgb   [NUM_CH];
  int                 step_no;
  bit                 fade_pend;
  bit                 fade_on;
  int                 ms_count;
  logic [MS_W-1:0]    reg_fade_ms;
  logic [STEPS_W-1:0] reg_steps;

  shown_color_t expected_colors [$];
  plan_row_t    directed_plan [26];

  int  n_errors;
  int  n_set;
  int  n_tick;
  int  n_results;
  int  n_refresh;
  int  n_fades_done;
  int  n_in_stalls;
  int  n_reg_settings;
  int  burst_left;
  bit  gaps_on;
  bit  stalls_on;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #LIMIT_NS;
    $display("timeout at %0t: %0d results still outstanding", $time, expected_colors.size());
    $display("TB_ERROR");
    $finish;
  end

  function automatic shown_color_t shown_now(logic refreshed);
    shown_color_t s;
    s.red       = shown_rgb[0];
    s.green     = shown_rgb[1];
    s.blue      = shown_rgb[2];
    s.refreshed = refreshed;
    s.fading    = fade_on;
    return s;
  endfunction

  function automatic shown_color_t advance_fade(fade_word_t w);
    int   n;
    int   c;
    int   d;
    int   mag;
    int   share;
    int   v;
    logic refreshed;
    refreshed = 1'b0;
    n = (reg_steps == '0) ? 1 : int'(reg_steps);
    if (w.cmd == CMD_SET) begin
      goal_rgb[0] = w.red;
      goal_rgb[1] = w.green;
      goal_rgb[2] = w.blue;
      fade_pend = 1'b1;
      return shown_now(1'b0);
    end
    if (ms_count != int'(MS_MAX)) ms_count++;
    if (fade_pend) begin
      // effect playing: request waits, fade frozen
      if (w.effect_selected && w.light_on) return shown_now(1'b0);
      fade_pend = 1'b0;
      if (reg_fade_ms == '0 || w.effect_selected) begin
        for (c = 0; c < NUM_CH; c++) shown_rgb[c] = goal_rgb[c];
        fade_on = 1'b0;
        refreshed = 1'b1;
      end else begin
        fade_on = 1'b1;
        step_no = 1;
        for (c = 0; c < NUM_CH; c++) begin
          d = int'(goal_rgb[c]) - int'(shown_rgb[c]);
          quot_rgb[c] = d / n;
          rem_rgb[c]  = d % n;
        end
      end
    end
    if (fade_on) begin
      if (ms_count > int'(reg_fade_ms) / n || ms_count == int'(MS_MAX)) begin
        ms_count = 0;
        for (c = 0; c < NUM_CH; c++) begin
          mag = (rem_rgb[c] < 0) ? -rem_rgb[c] : rem_rgb[c];
          share = 0;
          if ((step_no * mag) / n > ((step_no - 1) * mag) / n)
            share = (quot_rgb[c] < 0 || rem_rgb[c] < 0) ? -1 : 1;
          v = int'(shown_rgb[c]) + quot_rgb[c] + share;
          shown_rgb[c] = v[COLOR_W-1:0];
        end
        step_no = (step_no + 1) & IDX_MASK;
        refreshed = 1'b1;
      end
      if (step_no > n) begin
        fade_on = 1'b0;
        n_fades_done++;
      end
    end
    return shown_now(refreshed);
  endfunction

  function automatic plan_row_t word_row(logic cmd, logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                                         logic [COLOR_W-1:0] b, logic eff, logic on);
    plan_row_t row;
    row = '0;
    row.kind                 = ROW_WORD;
    row.word.cmd             = cmd;
    row.word.red             = r;
    row.word.green           = g;
    row.word.blue            = b;
    row.word.effect_selected = eff;
    row.word.light_on        = on;
    return row;
  endfunction

  function automatic plan_row_t shows(plan_row_t row, logic [COLOR_W-1:0] r,
                                      logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b,
                                      logic rf, logic fd);
    plan_row_t t;
    t = row;
    t.typed = 1'b1;
    t.want  = '{r, g, b, rf, fd};
    return t;
  endfunction

  function automatic plan_row_t regs_row(logic [MS_W-1:0] ms, logic [STEPS_W-1:0] sc);
    plan_row_t row;
    row = '0;
    row.kind    = ROW_REGS;
    row.fade_ms = ms;
    row.steps   = sc;
    return row;
  endfunction

  task automatic push_word(fade_word_t w, logic typed, shown_color_t want);
    shown_color_t pred;
    int           gap;
    in_ch.valid           <= 1'b1;
    in_ch.cmd             <= w.cmd;
    in_ch.red             <= w.red;
    in_ch.green           <= w.green;
    in_ch.blue            <= w.blue;
    in_ch.effect_selected <= w.effect_selected;
    in_ch.light_on        <= w.light_on;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = advance_fade(w);
    expected_colors.push_back(typed ? want : pred);
    if (w.cmd == CMD_SET) n_set++;
    else n_tick++;
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 6);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_colors.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_TRANSITION_MS: reg_fade_ms = val;
      CFG_STEP_COUNT:    reg_steps = val[STEPS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(logic [MS_W-1:0] ms, logic [STEPS_W-1:0] sc);
    wait_idle();
    write_reg(CFG_TRANSITION_MS, ms);
    write_reg(CFG_STEP_COUNT, CFG_DATA_W'(sc));
    cfg_ch.valid <= 1'b0;
    n_reg_settings++;
  endtask

  task automatic check_field(string name, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    shown_color_t want;
    if (rst_n && in_ch.valid && !in_ch.ready) n_in_stalls++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (out_ch.refreshed === 1'b1) n_refresh++;
      if (expected_colors.size() == 0) begin
        $display("%0t ns: unexpected word, expected none, got %0d %0d %0d r%0d f%0d", $time,
                 out_ch.out_red, out_ch.out_green, out_ch.out_blue, out_ch.refreshed,
                 out_ch.fading);
        n_errors++;
      end else begin
        want = expected_colors.pop_front();
        check_field("red", want.red, out_ch.out_red);
        check_field("green", want.green, out_ch.out_green);
        check_field("blue", want.blue, out_ch.out_blue);
        check_field("refreshed", COLOR_W'(want.refreshed), COLOR_W'(out_ch.refreshed));
        check_field("fading", COLOR_W'(want.fading), COLOR_W'(out_ch.fading));
      end
    end
  end

  // receiver: random short stalls, plus one long hold on request
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stalls_on && stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    fade_profile_t prof;
    fade_word_t    w;
    int            roll;
    int            c;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.cmd             <= CMD_TICK;
    in_ch.red             <= '0;
    in_ch.green           <= '0;
    in_ch.blue            <= '0;
    in_ch.effect_selected <= 1'b0;
    in_ch.light_on        <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_TRANSITION_MS;
    cfg_ch.data           <= '0;

    for (c = 0; c < NUM_CH; c++) begin
      shown_rgb[c] = '0;
      goal_rgb[c]  = '0;
      quot_rgb[c]  = 0;
      rem_rgb[c]   = 0;
    end
    step_no     = 0;
    fade_pend   = 1'b0;
    fade_on     = 1'b0;
    ms_count    = 0;
    reg_fade_ms = TRANSITION_MS_RST;
    reg_steps   = STEP_COUNT_RST;
    n_errors = 0; n_set = 0; n_tick = 0; n_results = 0; n_refresh = 0;
    n_fades_done = 0; n_in_stalls = 0; n_reg_settings = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;

    directed_plan = '{
      shows(word_row(CMD_TICK, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0),
      shows(word_row(CMD_SET, 255, 255, 255, 0, 1), 0, 0, 0, 0, 0),
      shows(word_row(CMD_TICK, 0, 0, 0, 1, 1), 0, 0, 0, 0, 0),
      shows(word_row(CMD_TICK, 0, 0, 0, 1, 0), 255, 255, 255, 1, 0),
      shows(word_row(CMD_SET, 0, 128, 255, 0, 1), 255, 255, 255, 0, 0),
      regs_row(16'd0, STEP_COUNT_RST),
      shows(word_row(CMD_TICK, 0, 0, 0, 0, 1), 0, 128, 255, 1, 0),
      regs_row(16'd1, 8'd0),
      shows(word_row(CMD_SET, 255, 0, 1, 0, 1), 0, 128, 255, 0, 0),
      shows(word_row(CMD_TICK, 0, 0, 0, 0, 1), 255, 0, 1, 1, 0),
      regs_row(MS_MAX, 8'd255),
      shows(word_row(CMD_SET, 0, 255, 0, 0, 1), 255, 0, 1, 0, 0),
      word_row(CMD_TICK, 8'h5a, 8'ha5, 8'hff, 0, 1),
      word_row(CMD_TICK, 0, 0, 0, 0, 0),
      word_row(CMD_TICK, 0, 0, 0, 1, 0),
      word_row(CMD_SET, 128, 128, 128, 1, 1),
      word_row(CMD_TICK, 0, 0, 0, 1, 1),
      shows(word_row(CMD_TICK, 0, 0, 0, 1, 0), 128, 128, 128, 1, 0),
      regs_row(16'd3, 8'd3),
      word_row(CMD_SET, 10, 0, 255, 0, 1),
      word_row(CMD_TICK, 0, 0, 0, 0, 1),
      word_row(CMD_TICK, 0, 0, 0, 0, 0),
      word_row(CMD_TICK, 0, 0, 0, 1, 0),
      word_row(CMD_TICK, 0, 0, 0, 0, 1),
      word_row(CMD_TICK, 8'hff, 8'hff, 8'hff, 0, 1),
      word_row(CMD_TICK, 0, 0, 0, 0, 1)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_REGS)
        set_registers(directed_plan[i].fade_ms, directed_plan[i].steps);
      else
        push_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      prof = fade_profile_t'(p % 6);
      case (prof)
        PROF_SHORT:  set_registers(MS_W'($urandom_range(1, 40)),
                                   STEPS_W'($urandom_range(1, 12)));
        PROF_JUMP:   set_registers(16'd0, STEPS_W'($urandom_range(0, 255)));
        PROF_DENSE:  set_registers(MS_W'($urandom_range(0, 8)), 8'd255);
        PROF_SINGLE: set_registers(MS_W'($urandom_range(20, 300)), 8'd0);
        PROF_MIXED:  set_registers(MS_W'($urandom_range(1, 120)),
                                   STEPS_W'($urandom_range(1, 60)));
        default:     set_registers(MS_W'($urandom_range(0, 65535)),
                                   STEPS_W'($urandom_range(0, 255)));
      endcase
      gaps_on   = (p != 0 && p != 4) && ($urandom_range(0, 3) != 0);
      stalls_on = (p != 0 && p != 4) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == 4 && k == 20) hold_req = 1'b1;
        roll = $urandom_range(0, 99);
        w.red   = COLOR_W'($urandom_range(0, 255));
        w.green = COLOR_W'($urandom_range(0, 255));
        w.blue  = COLOR_W'($urandom_range(0, 255));
        if (roll < 8) begin
          w.cmd             = 1'($urandom_range(0, 1));
          w.effect_selected = 1'($urandom_range(0, 1));
          w.light_on        = 1'($urandom_range(0, 1));
        end else if (!(fade_pend || fade_on) && roll < 70) begin
          w.cmd             = CMD_SET;
          w.effect_selected = ($urandom_range(0, 7) == 0);
          w.light_on        = ($urandom_range(0, 7) != 0);
        end else begin
          w.cmd             = CMD_TICK;
          w.effect_selected = ($urandom_range(0, 9) == 0);
          w.light_on        = ($urandom_range(0, 5) != 0);
        end
        push_word(w, 1'b0, '0);
      end
    end

    // longest step delay: the fade starts and holds its first step
    set_registers(MS_MAX, 8'd1);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    w = '0;
    w.cmd      = CMD_SET;
    w.red      = COLOR_W'($urandom_range(0, 255));
    w.green    = COLOR_W'($urandom_range(0, 255));
    w.blue     = COLOR_W'($urandom_range(0, 255));
    w.light_on = 1'b1;
    push_word(w, 1'b0, '0);
    w.cmd = CMD_TICK;
    push_word(w, 1'b0, '0);
    push_word(w, 1'b0, '0);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d set and %0d tick words over %0d register settings, %0d results checked.",
             n_set, n_tick, n_reg_settings, n_results);
    $display("Saw %0d color writes, %0d finished fades, %0d input stall cycles; %0d mismatches.",
             n_refresh, n_fades_done, n_in_stalls, n_errors);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
